FILE: rtl/core/ccw_pkg.sv
// ----------------------------------------------------------------------------
// ccw_pkg
// Shared constants, codes and index helpers for the cascaded coincidence window.
// ----------------------------------------------------------------------------
package ccw_pkg;

  // ring geometry and timestamp width
  localparam int RingDepth = 32;
  localparam int TimeBits  = 48;
  localparam int IdxW      = $clog2(RingDepth);
  localparam int EntryW    = TimeBits + 1;

  // field widths fixed by the interface
  localparam int IdxOutW   = 5;
  localparam int WidthW    = 32;
  localparam int CutW      = 6;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 32;

  // comparison widths
  localparam int DiffW     = (TimeBits > WidthW) ? TimeBits : WidthW;
  localparam int CmpW      = (IdxW > CutW) ? IdxW : CutW;

  // result budget per request
  localparam int MaxOut    = 64;
  localparam int ResCntW   = $clog2(MaxOut + 1);

  // reset values of the configuration registers
  localparam logic [WidthW-1:0] PresortWidthRst  = WidthW'(50);
  localparam logic [WidthW-1:0] SortWidthRst     = WidthW'(100);
  localparam logic [CutW-1:0]   PresortCutoffRst = CutW'(16);
  localparam logic [CutW-1:0]   CoincCutoffRst   = CutW'(16);

  typedef enum logic [1:0] {
    CmdEnter = 2'd0,
    CmdExit  = 2'd1,
    CmdClose = 2'd2,
    CmdSkip  = 2'd3
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    RegPresortWidth  = 2'd0,
    RegSortWidth     = 2'd1,
    RegPresortCutoff = 2'd2,
    RegCoincCutoff   = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    StIdle,
    StPresortChk,
    StPresortDiff,
    StPresortDec,
    StSortChk,
    StSortDiff,
    StSortDec,
    StEnter
  } state_t;

  // ring index arithmetic
  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] i);
    return (i == IdxW'(RingDepth - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] prev_idx(input logic [IdxW-1:0] i);
    return (i == '0) ? IdxW'(RingDepth - 1) : i - 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] occupancy(input logic [IdxW-1:0] from,
                                                input logic [IdxW-1:0] to);
    logic [IdxW:0] span;
    span = (to >= from) ? ({1'b0, to} - {1'b0, from})
                        : ({1'b0, to} + (IdxW+1)'(RingDepth) - {1'b0, from});
    return span[IdxW-1:0];
  endfunction

  function automatic logic [TimeBits-1:0] abs_diff(input logic [TimeBits-1:0] a,
                                                  input logic [TimeBits-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

FILE: rtl/core/ccw_ram.sv
// ----------------------------------------------------------------------------
// ccw_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ccw_ram #(
  parameter int Width = 8,
  parameter int Depth = 32,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [Width-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [Width-1:0] rd_data
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/cascaded_coincidence_window.sv
// ----------------------------------------------------------------------------
// cascaded_coincidence_window
// Two-stage sliding time-coincidence window over a ring of timestamped events.
// ----------------------------------------------------------------------------
// Each accepted event is stored in a 32-entry ring and then drives two window
// starts forward: the presort window and, for every entry leaving it, the
// coincidence window. One command is sent per window departure, followed by a
// presort enter command marked as last; an event sends at most 64 commands
// and the 64th is marked as last. All timestamps sit in a single RAM with one
// read port, and every comparison of a window start costs one RAM read and
// passes through an issue, a difference and a decision state. Output stalls
// hold the sequence only while a command waits to be taken. Configuration
// writes are always ready and must only be issued while no event is in flight.
module cascaded_coincidence_window
  import ccw_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // event requests
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [TimeBits-1:0] event_time,
  input  logic                chan_valid,
  // command results
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          command_kind,
  output logic [IdxOutW-1:0]  start_index,
  output logic [IdxOutW-1:0]  end_index,
  output logic                last_result,
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  state_t state, state_next;

  // configuration registers
  logic [WidthW-1:0] presort_width;
  logic [WidthW-1:0] sort_width;
  logic [CutW-1:0]   presort_cutoff;
  logic [CutW-1:0]   coinc_cutoff;

  // window pointers
  logic [IdxW-1:0] write_pointer;
  logic [IdxW-1:0] presort_start;
  logic [IdxW-1:0] sort_start;

  // working registers for the request in flight
  logic [TimeBits-1:0] new_time;
  logic [TimeBits-1:0] ins_time;
  logic [TimeBits-1:0] dt;
  logic                cur_valid;
  logic [ResCntW-1:0]  res_cnt;

  // ram interface
  logic                ram_wr_en;
  logic                ram_rd_en;
  logic [IdxW-1:0]     ram_rd_addr;
  logic [EntryW-1:0]   ram_rd_data;
  logic [TimeBits-1:0] rd_time;
  logic                rd_valid;

  // decision and emission
  logic                accept;
  logic                out_free;
  logic                res_full;
  logic                p_retire;
  logic                s_retire;
  logic                emit_req;
  logic                emit_go;
  logic                emit_fire;
  cmd_t                emit_kind;
  logic [IdxW-1:0]     emit_start;
  logic [IdxW-1:0]     emit_end;

  assign in_stall  = (state != StIdle);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign res_full  = (res_cnt == ResCntW'(MaxOut));
  assign emit_go   = !emit_req || res_full || out_free;
  assign emit_fire = emit_req && !res_full && out_free;

  assign ram_wr_en = accept;
  assign rd_time   = ram_rd_data[TimeBits-1:0];
  assign rd_valid  = ram_rd_data[TimeBits];

  // retirement rules
  assign p_retire = (DiffW'(dt) >= DiffW'(presort_width)) ||
                    (CmpW'(occupancy(presort_start, write_pointer)) >= CmpW'(presort_cutoff));
  assign s_retire = (DiffW'(dt) >= DiffW'(sort_width)) ||
                    (CmpW'(occupancy(sort_start, presort_start)) > CmpW'(coinc_cutoff));

  ccw_ram #(
    .Width (EntryW),
    .Depth (RingDepth)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (write_pointer),
    .wr_data ({chan_valid, event_time}),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      StIdle: begin
        if (accept) state_next = StPresortChk;
      end
      StPresortChk: begin
        state_next = (presort_start == write_pointer) ? StEnter : StPresortDiff;
      end
      StPresortDiff: begin
        state_next = StPresortDec;
      end
      StPresortDec: begin
        if (!p_retire) state_next = StEnter;
        else if (emit_go) state_next = StSortChk;
      end
      StSortChk: begin
        state_next = (sort_start == presort_start) ? StPresortChk : StSortDiff;
      end
      StSortDiff: begin
        state_next = StSortDec;
      end
      StSortDec: begin
        if (!s_retire) state_next = StPresortChk;
        else if (emit_go) state_next = StSortChk;
      end
      StEnter: begin
        if (emit_go) state_next = StIdle;
      end
      default: state_next = StIdle;
    endcase
  end

  // outputs of the sequencer: ram reads and command requests
  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = presort_start;
    emit_req    = 1'b0;
    emit_kind   = CmdEnter;
    emit_start  = presort_start;
    emit_end    = write_pointer;
    unique case (state)
      StPresortChk: begin
        ram_rd_en   = (presort_start != write_pointer);
        ram_rd_addr = presort_start;
      end
      StSortChk: begin
        ram_rd_en   = (sort_start != presort_start);
        ram_rd_addr = sort_start;
      end
      StPresortDec: begin
        emit_req   = p_retire;
        emit_kind  = CmdExit;
        emit_start = presort_start;
        emit_end   = prev_idx(write_pointer);
      end
      StSortDec: begin
        emit_req   = s_retire;
        emit_kind  = cur_valid ? CmdClose : CmdSkip;
        emit_start = sort_start;
        emit_end   = prev_idx(presort_start);
      end
      StEnter: begin
        emit_req   = 1'b1;
        emit_kind  = CmdEnter;
        emit_start = presort_start;
        emit_end   = write_pointer;
      end
      default: begin
        ram_rd_en = 1'b0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      presort_width  <= PresortWidthRst;
      sort_width     <= SortWidthRst;
      presort_cutoff <= PresortCutoffRst;
      coinc_cutoff   <= CoincCutoffRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        RegPresortWidth:  presort_width  <= cfg_data[WidthW-1:0];
        RegSortWidth:     sort_width     <= cfg_data[WidthW-1:0];
        RegPresortCutoff: presort_cutoff <= cfg_data[CutW-1:0];
        RegCoincCutoff:   coinc_cutoff   <= cfg_data[CutW-1:0];
        default:          presort_width  <= presort_width;
      endcase
    end
  end

  // window pointers and result count
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      presort_start <= '0;
      sort_start    <= '0;
      res_cnt       <= '0;
    end else begin
      if (accept) begin
        res_cnt <= '0;
      end else if (emit_fire) begin
        res_cnt <= res_cnt + 1'b1;
      end
      // presort start moves on once its entry has settled in the sort window
      if ((state == StSortChk && sort_start == presort_start) ||
          (state == StSortDec && !s_retire)) begin
        presort_start <= next_idx(presort_start);
      end
      if (state == StSortDec && s_retire && emit_go) begin
        sort_start <= next_idx(sort_start);
      end
      if (state == StEnter && emit_go) begin
        write_pointer <= next_idx(write_pointer);
      end
    end
  end

  // datapath: new event time, inserted time and absolute differences
  always_ff @(posedge clk) begin
    if (accept) begin
      new_time <= event_time;
    end
    if (state == StPresortDiff) begin
      dt       <= abs_diff(new_time, rd_time);
      ins_time <= rd_time;
    end
    if (state == StSortDiff) begin
      dt        <= abs_diff(ins_time, rd_time);
      cur_valid <= rd_valid;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      command_kind <= emit_kind;
      start_index  <= IdxOutW'(emit_start);
      end_index    <= IdxOutW'(emit_end);
      last_result  <= (emit_kind == CmdEnter) || (res_cnt == ResCntW'(MaxOut - 1));
    end
  end

endmodule

FILE: rtl/core/ccw_checker.sv
// ----------------------------------------------------------------------------
// ccw_checker
// Port-level checks for the cascaded coincidence window, bound to the top level.
// ----------------------------------------------------------------------------
module ccw_checker
  import ccw_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [1:0]          command_kind,
  input logic [IdxOutW-1:0]  start_index,
  input logic [IdxOutW-1:0]  end_index,
  input logic                last_result
);

  // a stalled command stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("command dropped while stalled");

  // a stalled command keeps its fields
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(command_kind) && $stable(start_index) &&
                               $stable(end_index) && $stable(last_result))
    else $error("command changed while stalled");

  // an accepted event keeps the input stalled while it is processed
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before the event was processed");

  // a presort enter always closes the commands of its event
  a_enter_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && command_kind == CmdEnter |-> last_result)
    else $error("presort enter without last mark");

  // the input stays stalled while a command that is not the last is offered
  a_busy_while_owed: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_result |-> in_stall)
    else $error("new event taken before the last command of the previous one");

endmodule

bind cascaded_coincidence_window ccw_checker u_ccw_checker (.*);

FILE: dv/tb_cascaded_coincidence_window.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cascaded_coincidence_window
// Self-checking bench for the two-stage coincidence window over the event ring.
// ----------------------------------------------------------------------------
// Event requests are queued by the stimulus process and presented by a driver
// with random gaps outside the final stretch. Each accepted request is run
// through a local model of the presort and coincidence windows, which queues
// the commands it must cause. The monitor compares every command taken from
// the block with the oldest queued command. Register settings change between
// phases while idle, with zero and maximum widths and cutoffs of 0 and 32.
// ----------------------------------------------------------------------------
module tb_cascaded_coincidence_window;
  import ccw_pkg::*;

  localparam int CycleLimit   = 3_000_000;
  localparam int HoldCycles   = 300;
  localparam int SettleCycles = 40;

  typedef struct {
    logic [TimeBits-1:0] tstamp;
    logic                mapped;
  } event_req_t;

  typedef struct {
    cmd_t               kind;
    logic [IdxOutW-1:0] start_idx;
    logic [IdxOutW-1:0] end_idx;
    logic               closes_event;
  } window_cmd_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // block ports
  logic                in_valid   = 1'b0;
  logic                in_stall;
  logic [TimeBits-1:0] event_time = '0;
  logic                chan_valid = 1'b0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic [1:0]          command_kind;
  logic [IdxOutW-1:0]  start_index;
  logic [IdxOutW-1:0]  end_index;
  logic                last_result;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index  = '0;
  logic [CfgDataW-1:0] cfg_data   = '0;

  cascaded_coincidence_window DUT (
    .clk, .rst,
    .in_valid, .in_stall, .event_time, .chan_valid,
    .out_valid, .out_stall, .command_kind, .start_index, .end_index, .last_result,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  // pending requests and commands still owed by the block
  event_req_t  pending_events[$];
  window_cmd_t owed_commands[$];

  // local window model state
  logic [TimeBits-1:0] ring_time [RingDepth];
  logic                ring_mapped [RingDepth];
  logic [IdxOutW-1:0]  write_slot;
  logic [IdxOutW-1:0]  presort_head;
  logic [IdxOutW-1:0]  coinc_head;
  logic [WidthW-1:0]   presort_width_q = PresortWidthRst;
  logic [WidthW-1:0]   sort_width_q    = SortWidthRst;
  logic [CutW-1:0]     presort_cutoff_q = PresortCutoffRst;
  logic [CutW-1:0]     coinc_cutoff_q   = CoincCutoffRst;
  int unsigned         cmds_this_event;

  // run control
  int unsigned         error_count = 0;
  int unsigned         cycle_count = 0;
  logic                ev_taken    = 1'b0;
  bit                  idle_on     = 1'b1;
  bit                  hold_armed  = 1'b0;
  int unsigned         hold_left   = 0;
  int unsigned         stall_left  = 0;
  int unsigned         in_gap      = 0;
  logic [TimeBits-1:0] stream_time = '0;

  function automatic logic [TimeBits-1:0] time_gap(input logic [TimeBits-1:0] a,
                                                   input logic [TimeBits-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // queue one command unless this request has used up its budget
  function automatic void owe_command(input cmd_t kind, input logic [IdxOutW-1:0] s,
                                      input logic [IdxOutW-1:0] e);
    window_cmd_t c;
    if (cmds_this_event < MaxOut) begin
      c.kind         = kind;
      c.start_idx    = s;
      c.end_idx      = e;
      c.closes_event = 1'b0;
      owed_commands.push_back(c);
      cmds_this_event++;
    end
  endfunction

  // store the event, slide both windows and queue the resulting commands
  function automatic void slide_windows(input event_req_t ev);
    logic [IdxOutW-1:0]  slot;
    logic [IdxOutW-1:0]  leaving;
    logic [IdxOutW-1:0]  span;
    logic [TimeBits-1:0] inserted_time;
    window_cmd_t         tail;
    slot = write_slot;
    cmds_this_event = 0;
    ring_time[slot]   = ev.tstamp;
    ring_mapped[slot] = ev.mapped;
    while (presort_head != slot) begin
      leaving = presort_head;
      span    = slot - leaving;
      if (time_gap(ev.tstamp, ring_time[leaving]) < TimeBits'(presort_width_q) &&
          CutW'(span) < presort_cutoff_q)
        break;
      owe_command(CmdExit, leaving, slot - 1'b1);
      // the departing entry joins the coincidence window
      inserted_time = ring_time[leaving];
      while (coinc_head != leaving) begin
        span = leaving - coinc_head;
        if (time_gap(inserted_time, ring_time[coinc_head]) < TimeBits'(sort_width_q) &&
            CutW'(span) <= coinc_cutoff_q)
          break;
        owe_command(ring_mapped[coinc_head] ? CmdClose : CmdSkip, coinc_head,
                    leaving - 1'b1);
        coinc_head = coinc_head + 1'b1;
      end
      presort_head = leaving + 1'b1;
    end
    owe_command(CmdEnter, presort_head, slot);
    write_slot = slot + 1'b1;
    tail = owed_commands.pop_back();
    tail.closes_event = 1'b1;
    owed_commands.push_back(tail);
  endfunction

  // request driver, changes on the falling edge
  always @(negedge clk) begin
    if (!rst && !(in_valid && !ev_taken)) begin
      if (in_gap != 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 17);
        in_valid <= 1'b0;
      end else if (pending_events.size() != 0) begin
        in_valid   <= 1'b1;
        event_time <= pending_events[0].tstamp;
        chan_valid <= pending_events[0].mapped;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // command receiver stalls, including the long hold-off
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_armed) begin
      hold_armed = 1'b0;
      hold_left  = HoldCycles - 1;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 17);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: check taken commands, then model newly accepted requests
  always @(posedge clk) begin
    window_cmd_t want;
    ev_taken = 1'b0;
    if (!rst && out_valid && !out_stall) begin
      if (owed_commands.size() == 0) begin
        error_count++;
        $display("%0t unexpected command: kind %0d start %0d end %0d last %0b",
                 $time, command_kind, start_index, end_index, last_result);
      end else begin
        want = owed_commands.pop_front();
        if (command_kind !== want.kind || start_index !== want.start_idx ||
            end_index !== want.end_idx || last_result !== want.closes_event) begin
          error_count++;
          $display("%0t command mismatch: expected kind %0d start %0d end %0d last %0b",
                   $time, want.kind, want.start_idx, want.end_idx, want.closes_event);
          $display("%0t                   actual   kind %0d start %0d end %0d last %0b",
                   $time, command_kind, start_index, end_index, last_result);
        end
      end
    end
    if (!rst && in_valid && !in_stall) begin
      ev_taken = 1'b1;
      slide_windows(pending_events.pop_front());
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL cascaded_coincidence_window");
      $finish;
    end
  end

  function automatic void push_event(input logic [TimeBits-1:0] t, input logic m);
    event_req_t ev;
    ev.tstamp = t;
    ev.mapped = m;
    pending_events.push_back(ev);
  endfunction

  // mostly ordered time streams, with jumps, reversals and wraps mixed in
  function automatic void gen_events(input int unsigned count, input int unsigned span);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 80)
        stream_time = stream_time + $urandom_range(0, span);
      else if (pick < 86)
        stream_time = {16'($urandom), $urandom};
      else if (pick < 92)
        stream_time = stream_time - $urandom_range(0, span);
      else if (pick < 96)
        stream_time = '1 - $urandom_range(0, span);
      else
        stream_time = TimeBits'($urandom_range(0, span));
      push_event(stream_time, $urandom_range(0, 4) != 0);
    end
  endfunction

  // wait until every request is taken, every command seen and the block is idle
  task automatic wait_idle();
    while (pending_events.size() != 0 || owed_commands.size() != 0 || in_stall)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegPresortWidth:  presort_width_q  = data;
      RegSortWidth:     sort_width_q     = data;
      RegPresortCutoff: presort_cutoff_q = data[CutW-1:0];
      RegCoincCutoff:   coinc_cutoff_q   = data[CutW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one register setting followed by a batch of events
  task automatic run_phase(input logic [WidthW-1:0] pw, input logic [WidthW-1:0] sw,
                           input int unsigned pc, input int unsigned cc,
                           input int unsigned count, input int unsigned span,
                           input bit hold);
    write_reg(RegPresortWidth, pw);
    write_reg(RegSortWidth, sw);
    write_reg(RegPresortCutoff, CfgDataW'(pc));
    write_reg(RegCoincCutoff, CfgDataW'(cc));
    if (hold)
      hold_armed = 1'b1;
    gen_events(count, span);
    wait_idle();
  endtask

  initial begin
    logic [WidthW-1:0] pw;
    write_slot   = '0;
    presort_head = '0;
    coinc_head   = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: unmapped entry, width retirement, reversed time, extreme stamps
    push_event(48'd0, 1'b0);
    push_event(48'd10, 1'b1);
    push_event(48'd20, 1'b1);
    push_event(48'd75, 1'b1);
    push_event(48'd40, 1'b0);
    push_event('1, 1'b1);
    push_event(48'd0, 1'b1);
    push_event(48'h5555_5555_5555, 1'b0);
    push_event(48'hAAAA_AAAA_AAAA, 1'b1);
    // equal stamps until the presort occupancy cutoff forces entries out
    for (int i = 0; i < 16; i++)
      push_event(48'hAAAA_AAAA_AAAA, i[0]);
    wait_idle();

    // register extremes, then mid-range settings
    run_phase('0, '0, 0, 0, 45, 20, 1'b0);
    run_phase('1, '1, 32, 32, 50, 4000, 1'b0);
    run_phase(32'd200, 32'd1000, 4, 8, 60, 150, 1'b1);
    run_phase(PresortWidthRst, SortWidthRst, 16, 16, 50, 80, 1'b0);
    repeat (3) begin
      pw = $urandom_range(1, 3000);
      run_phase(pw, pw + $urandom_range(0, 3000), $urandom_range(1, 32),
                $urandom_range(0, 32), 50, 2 * pw, 1'b0);
    end

    // final stretch without idling
    idle_on = 1'b0;
    run_phase(32'd300, 32'd700, 12, 20, 60, 400, 1'b0);

    if (error_count == 0)
      $display("PASS cascaded_coincidence_window");
    else
      $display("FAIL cascaded_coincidence_window");
    $finish;
  end

endmodule
